### hdl/clpx_pkg.sv
// ----------------------------------------------------------------------------
// clpx_pkg
// Shared types and constants for the charlieplexed level LED scanner.
// ----------------------------------------------------------------------------
package clpx_pkg;

  // command codes
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // per-LED pattern codes
  localparam logic [1:0] PAT_OFF   = 2'd0;
  localparam logic [1:0] PAT_ON    = 2'd1;
  localparam logic [1:0] PAT_BLINK = 2'd2;

  // scanner phase codes
  localparam logic PH_UPDATE = 1'b0;
  localparam logic PH_SCAN   = 1'b1;

  localparam logic [7:0] CODE_MAX = 8'd7;

  // blink timing in milliseconds
  localparam int BLINK_PERIOD     = 500;
  localparam int BLINK_DARK_AFTER = 250;

  // time_ms mod 500 = 4 * ((time_ms >> 2) mod 125) + time_ms[1:0]
  localparam int QUARTER     = BLINK_PERIOD / 4;
  localparam int RECIP_SHIFT = 37;
  localparam longint unsigned RECIP_M =
    ((64'd1 << RECIP_SHIFT) + 64'(QUARTER) - 64'd1) / 64'(QUARTER);

  typedef struct packed {
    logic        command;
    logic [7:0]  code;
    logic        clear;
    logic [31:0] time_ms;
  } in_word_t;

  typedef struct packed {
    logic       pin_one;
    logic       pin_two;
    logic       pin_three;
    logic [1:0] lit_index;
  } out_word_t;

  // what one scan step hands to the output path
  typedef struct packed {
    logic       res;
    logic       lit;
    logic [1:0] idx;
    logic       blink;
  } scan_step_t;

endpackage

### hdl/clpx_scan.sv
// ----------------------------------------------------------------------------
// clpx_scan
// Pattern store and two-phase scanner state; one step per accepted word.
// ----------------------------------------------------------------------------
module clpx_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  clpx_pkg::in_word_t    word,
  output clpx_pkg::scan_step_t  step
);

  logic [1:0] req_r   [4];
  logic [1:0] req_nxt [4];
  logic [1:0] snap_r  [4];
  logic [1:0] snap_nxt[4];
  logic       phase_r, phase_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_comb begin
    logic [2:0] full;
    logic [2:0] pos_inc;
    logic [2:0] cnt_sum;
    logic       lit;
    logic [1:0] idx;

    req_nxt   = req_r;
    snap_nxt  = snap_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    step      = '0;

    full    = 3'((4'(word.code[2:0]) + 4'd1) >> 1);
    pos_inc = pos_r + 3'd1;
    cnt_sum = '0;
    for (int i = 0; i < 4; i++) begin
      cnt_sum = cnt_sum + 3'(req_r[i] != clpx_pkg::PAT_OFF);
    end
    lit = (cnt_r != 3'd0);
    idx = lit ? pos_r[1:0] : 2'd0;

    if (word.command == clpx_pkg::CMD_SET) begin
      if (word.code <= clpx_pkg::CODE_MAX) begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < full) begin
            req_nxt[i] = clpx_pkg::PAT_ON;
          end else if (3'(i) == full && !word.code[0]) begin
            req_nxt[i] = clpx_pkg::PAT_BLINK;
          end else begin
            req_nxt[i] = clpx_pkg::PAT_OFF;
          end
        end
      end
    end else if (word.clear || phase_r == clpx_pkg::PH_UPDATE) begin
      // update phase or clear: snapshot and count
      snap_nxt  = req_r;
      cnt_nxt   = cnt_sum;
      phase_nxt = clpx_pkg::PH_SCAN;
      if (word.clear) begin
        pos_nxt = '0;
      end
    end else begin
      step.res   = 1'b1;
      step.lit   = lit;
      step.idx   = idx;
      step.blink = (snap_r[idx] == clpx_pkg::PAT_BLINK);
      if (pos_inc >= cnt_r) begin
        pos_nxt   = '0;
        phase_nxt = clpx_pkg::PH_UPDATE;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        req_r[i]  <= clpx_pkg::PAT_OFF;
        snap_r[i] <= clpx_pkg::PAT_OFF;
      end
      phase_r <= clpx_pkg::PH_UPDATE;
      pos_r   <= '0;
      cnt_r   <= '0;
    end else if (step_en) begin
      req_r   <= req_nxt;
      snap_r  <= snap_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### hdl/charlieplex_level_led_scanner.sv
// ----------------------------------------------------------------------------
// charlieplex_level_led_scanner
// Four-LED level bar on three charlieplexed pins, one LED driven per scan tick.
// ----------------------------------------------------------------------------
//   channel | ports                        | payload
//   --------+------------------------------+--------------------------
//   input   | in_valid, in_stall, in_word  | command, code, clear, time_ms
//   output  | out_valid, out_stall, out_word | pins one..three, lit_index
//
// one word accepted per cycle while in_stall is low; a scan tick's output word
// passes the input register, the blink remainder multiply and the output register
// set and update ticks give no output word
// reset clears the pattern, the scanner state and all stage valids
// out_stall backs words up through the three registers before in_stall rises
module charlieplex_level_led_scanner (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  clpx_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output clpx_pkg::out_word_t  out_word
);

  clpx_pkg::in_word_t   s1_r;
  logic                 v1_r;
  clpx_pkg::scan_step_t step;

  logic       v2_r;
  logic       lit2_r;
  logic [1:0] idx2_r;
  logic       blink2_r;
  logic [6:0] qlo2_r;
  logic [8:0] tlo2_r;

  logic                v3_r;
  clpx_pkg::out_word_t out_r;
  clpx_pkg::out_word_t out_nxt;

  logic        ready1, ready2, ready3;
  logic [60:0] prod;
  logic [6:0]  rem_q;
  logic [8:0]  rem;
  logic        dark;
  logic        s_on;

  assign ready3   = !v3_r || !out_stall;
  assign ready2   = !v2_r || ready3;
  assign ready1   = !v1_r || ready2;
  assign in_stall = !ready1;

  clpx_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (v1_r && ready2),
    .word    (s1_r),
    .step    (step)
  );

  // quotient of (time_ms >> 2) by a quarter period
  assign prod = 61'(s1_r.time_ms[31:2]) * 61'(31'(clpx_pkg::RECIP_M));

  // remainder is below the quarter period, so seven low bits are enough
  assign rem_q = tlo2_r[8:2] - 7'(qlo2_r * 7'(clpx_pkg::QUARTER));
  assign rem   = {rem_q, tlo2_r[1:0]};
  assign dark  = rem > 9'(clpx_pkg::BLINK_DARK_AFTER);
  assign s_on  = !(blink2_r && dark);

  always_comb begin
    out_nxt           = '0;
    out_nxt.lit_index = idx2_r;
    if (lit2_r) begin
      case (idx2_r)
        2'd0: begin
          out_nxt.pin_three = s_on;
        end
        2'd1: begin
          out_nxt.pin_one = s_on;
          out_nxt.pin_two = s_on;
        end
        2'd2: begin
          out_nxt.pin_one = s_on;
        end
        default: begin
          out_nxt.pin_two   = s_on;
          out_nxt.pin_three = s_on;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= in_valid;
      end
      if (ready2) begin
        v2_r <= v1_r && step.res;
      end
      if (ready3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready1) begin
      s1_r <= in_word;
    end
    if (ready2) begin
      lit2_r   <= step.lit;
      idx2_r   <= step.idx;
      blink2_r <= step.blink;
      qlo2_r   <= prod[clpx_pkg::RECIP_SHIFT +: 7];
      tlo2_r   <= s1_r.time_ms[8:0];
    end
    if (ready3 && v2_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_word  = out_r;

  // stall only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && out_stall)
    else $error("input stalled with a free stage");

  // reciprocal quotient leaves a remainder below the quarter period
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> rem_q < 7'(clpx_pkg::QUARTER))
    else $error("blink remainder out of range");

  // pins one and three never lit together
  a_pin_pair: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> !(out_r.pin_one && out_r.pin_three))
    else $error("illegal pin combination");

endmodule

### bench/charlieplex_level_led_scanner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// charlieplex_level_led_scanner_tb
// Drives set and tick words into the scanner and checks every pin word that
// comes back. A directed table covers ignored codes, the empty bar, full and
// blinking bars, the dark half of the blink and mid-scan clears. Random
// traffic then runs under three idle and stall mixes. Each accepted word
// updates a local copy of the scanner, and each pin word is checked in order.
// ----------------------------------------------------------------------------
module charlieplex_level_led_scanner_tb;

  localparam int RANDOM_WORDS = 950;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    clpx_pkg::in_word_t  word;
    logic                typed;
    logic                has_pins;
    clpx_pkg::out_word_t pins;
  } plan_row_t;

  localparam clpx_pkg::out_word_t DARK = '{1'b0, 1'b0, 1'b0, 2'd0};

  localparam plan_row_t PLAN [25] = '{
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd0}, 1'b1, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd0}, 1'b1, 1'b1, DARK},
    '{'{clpx_pkg::CMD_SET, 8'd255, 1'b1, 32'hffffffff}, 1'b1, 1'b0, DARK},
    '{'{clpx_pkg::CMD_SET, 8'd8, 1'b0, 32'd0}, 1'b1, 1'b0, DARK},
    '{'{clpx_pkg::CMD_SET, 8'd7, 1'b0, 32'd0}, 1'b1, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd0}, 1'b1, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd0}, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 2'd0}},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd0}, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 2'd1}},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd0}, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 2'd2}},
    '{'{clpx_pkg::CMD_TICK, 8'hff, 1'b0, 32'hffffffff}, 1'b1, 1'b1,
      '{1'b0, 1'b1, 1'b1, 2'd3}},
    '{'{clpx_pkg::CMD_SET, 8'd0, 1'b0, 32'd0}, 1'b1, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b1, 32'd0}, 1'b1, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd251}, 1'b1, 1'b1, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd0}, 1'b0, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd250}, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 2'd0}},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd0}, 1'b0, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'hffffffff}, 1'b0, 1'b0, DARK},
    '{'{clpx_pkg::CMD_SET, 8'd6, 1'b0, 32'd0}, 1'b0, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd0}, 1'b0, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd251}, 1'b0, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b1, 32'd0}, 1'b1, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd0}, 1'b0, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd0}, 1'b0, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd0}, 1'b0, 1'b0, DARK},
    '{'{clpx_pkg::CMD_TICK, 8'd0, 1'b0, 32'd499}, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 2'd3}}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  clpx_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  clpx_pkg::out_word_t out_word;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bad_words = 0;
  int cycle_count = 0;

  // local copy of the scanner
  logic [1:0] bar_pattern [4];
  logic [1:0] bar_snapshot [4];
  logic       scanner_phase;
  logic [2:0] scanner_pos;
  logic [2:0] lit_leds;

  clpx_pkg::out_word_t pin_levels_q [$];

  charlieplex_level_led_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("charlieplex_level_led_scanner_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic void reset_scanner_copy();
    for (int i = 0; i < 4; i++) begin
      bar_pattern[i] = clpx_pkg::PAT_OFF;
      bar_snapshot[i] = clpx_pkg::PAT_OFF;
    end
    scanner_phase = clpx_pkg::PH_UPDATE;
    scanner_pos = '0;
    lit_leds = '0;
  endfunction

  // returns 1 when the word gives a pin word
  function automatic bit advance_scanner(input clpx_pkg::in_word_t w,
                                         output clpx_pkg::out_word_t pins);
    int full;
    logic [1:0] led;
    logic s;
    pins = '0;
    if (w.command == clpx_pkg::CMD_SET) begin
      if (w.code <= clpx_pkg::CODE_MAX) begin
        full = (int'(w.code) + 1) / 2;
        for (int i = 0; i < 4; i++) begin
          if (i < full) bar_pattern[i] = clpx_pkg::PAT_ON;
          else if (i == full && !w.code[0]) bar_pattern[i] = clpx_pkg::PAT_BLINK;
          else bar_pattern[i] = clpx_pkg::PAT_OFF;
        end
      end
      return 1'b0;
    end
    if (w.clear) begin
      scanner_phase = clpx_pkg::PH_UPDATE;
      scanner_pos = '0;
      lit_leds = '0;
      for (int i = 0; i < 4; i++) bar_snapshot[i] = clpx_pkg::PAT_OFF;
    end
    if (scanner_phase == clpx_pkg::PH_UPDATE) begin
      lit_leds = '0;
      for (int i = 0; i < 4; i++) begin
        bar_snapshot[i] = bar_pattern[i];
        if (bar_pattern[i] != clpx_pkg::PAT_OFF) lit_leds = lit_leds + 3'd1;
      end
      scanner_phase = clpx_pkg::PH_SCAN;
      return 1'b0;
    end
    led = scanner_pos[1:0];
    if (lit_leds == 0) begin
      led = 2'd0;
    end else begin
      s = !(bar_snapshot[led] == clpx_pkg::PAT_BLINK &&
            (w.time_ms % 32'(clpx_pkg::BLINK_PERIOD)) >
            32'(clpx_pkg::BLINK_DARK_AFTER));
      case (led)
        2'd0: pins.pin_three = s;
        2'd1: begin
          pins.pin_two = s;
          pins.pin_one = s;
        end
        2'd2: pins.pin_one = s;
        default: begin
          pins.pin_two = s;
          pins.pin_three = s;
        end
      endcase
    end
    pins.lit_index = led;
    scanner_pos = scanner_pos + 3'd1;
    if (scanner_pos >= lit_leds) begin
      scanner_pos = '0;
      scanner_phase = clpx_pkg::PH_UPDATE;
    end
    return 1'b1;
  endfunction

  function automatic clpx_pkg::in_word_t random_word();
    clpx_pkg::in_word_t w;
    w.code = 8'($urandom);
    w.clear = 1'($urandom);
    w.time_ms = $urandom;
    if ($urandom_range(99) < 25) begin
      w.command = clpx_pkg::CMD_SET;
      if ($urandom_range(9) != 0) w.code = 8'($urandom_range(7));
    end else begin
      w.command = clpx_pkg::CMD_TICK;
      w.clear = ($urandom_range(19) == 0);
      case ($urandom_range(3))
        0: w.time_ms = $urandom_range(8589933) * 500 + $urandom_range(249, 252);
        1: w.time_ms = $urandom_range(499);
        default: ;
      endcase
    end
    return w;
  endfunction

  // drive one word, wait for it to be taken, then book its pin word
  task automatic send_word(input clpx_pkg::in_word_t w, input bit typed,
                           input bit has_pins, input clpx_pkg::out_word_t typed_pins);
    clpx_pkg::out_word_t pins;
    bit gives;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_word <= '0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    gives = advance_scanner(w, pins);
    if (typed) begin
      gives = has_pins;
      pins = typed_pins;
    end
    if (gives) pin_levels_q.push_back(pins);
  endtask

  always @(posedge clk) begin : check_pins
    clpx_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pin_levels_q.size() == 0) begin
        if (bad_words < 10)
          $display("unexpected word: pins %b%b%b index %0d", out_word.pin_one,
                   out_word.pin_two, out_word.pin_three, out_word.lit_index);
        bad_words <= bad_words + 1;
      end else begin
        want = pin_levels_q.pop_front();
        if (out_word.pin_one !== want.pin_one || out_word.pin_two !== want.pin_two ||
            out_word.pin_three !== want.pin_three ||
            out_word.lit_index !== want.lit_index) begin
          if (bad_words < 10)
            $display("mismatch: expected pins %b%b%b index %0d, got %b%b%b index %0d",
                     want.pin_one, want.pin_two, want.pin_three, want.lit_index,
                     out_word.pin_one, out_word.pin_two, out_word.pin_three,
                     out_word.lit_index);
          bad_words <= bad_words + 1;
        end
      end
    end
  end

  initial begin
    reset_scanner_copy();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15;
    recv_stall_pct = 62;
    foreach (PLAN[i]) send_word(PLAN[i].word, PLAN[i].typed, PLAN[i].has_pins, PLAN[i].pins);

    for (int mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin
          send_idle_pct = 15;
          recv_stall_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_stall_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_WORDS / 3; n++) send_word(random_word(), 1'b0, 1'b0, DARK);
    end

    in_valid <= 1'b0;
    in_word <= '0;
    recv_stall_pct = 0;
    while (pin_levels_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (bad_words == 0 && pin_levels_q.size() == 0) begin
      $display("charlieplex_level_led_scanner_tb: PASS");
    end else begin
      $display("charlieplex_level_led_scanner_tb: FAIL");
    end
    $finish;
  end

endmodule
